// ===== design/pip_pkg.sv =====
package pip_pkg;

	// Coordinate width: signed fixed point, Q16.16 at 32 bits.
	localparam int COORD_BITS = 32;
	// Coordinate differences need one extra bit.
	localparam int DIFF_BITS  = COORD_BITS + 1;
	// Products of two differences are kept at full width.
	localparam int PROD_BITS  = 2 * DIFF_BITS;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_BITS-1:0]  diff_t;
	typedef logic signed [PROD_BITS-1:0]  prod_t;

	// Commands from the sequencer to the datapath.
	typedef struct packed {
		logic load;      // take the vertex of an accepted request
		logic first;     // the accepted vertex opens a polygon
		logic setup;     // evaluate edge conditions and differences
		logic close;     // edge runs from the current vertex to the first one
		logic mul1;      // first product into its register
		logic mul2;      // second product into its register
		logic cmp;       // compare products, toggle parity
		logic out_load;  // copy parity into the result register
	} pip_cmd_t;

	// Sign extension of a coordinate to difference width.
	function automatic diff_t sx(input coord_t c);
		sx = {c[COORD_BITS-1], c};
	endfunction

endpackage

// ===== design/pip_dp.sv =====
module pip_dp
	import pip_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  pip_cmd_t cmd,
	input  coord_t   vertex_x,
	input  coord_t   vertex_y,
	input  coord_t   query_x,
	input  coord_t   query_y,
	output logic     inside_res
);

	coord_t first_x_q, first_y_q, prev_x_q, prev_y_q, cur_x_q, cur_y_q;
	coord_t qx_q, qy_q;
	logic   parity_q;
	logic   en_q, dyneg_q;
	diff_t  dpy_q, dbx_q, dpx_q, dy_q;
	prod_t  p1_q, p2_q;
	logic   res_q;

	coord_t ax, ay, bx, by;
	logic   left, straddle;
	diff_t  op_a, op_b;
	prod_t  mul;
	logic   toggle;

	always_comb begin
		ax = cmd.close ? cur_x_q : prev_x_q;
		ay = cmd.close ? cur_y_q : prev_y_q;
		bx = cmd.close ? first_x_q : cur_x_q;
		by = cmd.close ? first_y_q : cur_y_q;
		left     = (ax <= qx_q) || (bx <= qx_q);
		straddle = ((ay < qy_q) && (by >= qy_q)) || ((by < qy_q) && (ay >= qy_q));
	end

	// One shared multiplier, used for both products of an edge.
	always_comb begin
		op_a = cmd.mul2 ? dpx_q : dpy_q;
		op_b = cmd.mul2 ? dy_q : dbx_q;
		mul  = prod_t'(op_a) * prod_t'(op_b);
	end

	assign toggle = en_q && ((!dyneg_q && (p1_q < p2_q)) || (dyneg_q && (p1_q > p2_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_x_q <= '0;
			first_y_q <= '0;
			prev_x_q  <= '0;
			prev_y_q  <= '0;
			cur_x_q   <= '0;
			cur_y_q   <= '0;
			qx_q      <= '0;
			qy_q      <= '0;
			parity_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				prev_x_q <= cur_x_q;
				prev_y_q <= cur_y_q;
				cur_x_q  <= vertex_x;
				cur_y_q  <= vertex_y;
				if (cmd.first) begin
					first_x_q <= vertex_x;
					first_y_q <= vertex_y;
					qx_q      <= query_x;
					qy_q      <= query_y;
					parity_q  <= 1'b0;
				end
			end
			if (cmd.cmp && toggle) begin
				parity_q <= !parity_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			en_q    <= left && straddle;
			dyneg_q <= by < ay;
			dpy_q   <= sx(qy_q) - sx(ay);
			dbx_q   <= sx(bx) - sx(ax);
			dpx_q   <= sx(qx_q) - sx(ax);
			dy_q    <= sx(by) - sx(ay);
		end
		if (cmd.mul1) begin
			p1_q <= mul;
		end
		if (cmd.mul2) begin
			p2_q <= mul;
		end
		if (cmd.out_load) begin
			res_q <= parity_q;
		end
	end

	assign inside_res = res_q;

endmodule

// ===== design/pip_ctrl.sv =====
module pip_ctrl
	import pip_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic     last_vertex,
	output logic     out_valid,
	input  logic     out_ready,
	output pip_cmd_t cmd
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_SETUP = 6'b000010,
		S_MUL1  = 6'b000100,
		S_MUL2  = 6'b001000,
		S_CMP   = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   at_start_q, last_q, close_q, out_valid_q;
	logic   accept, out_free;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.close    = close_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.load  = 1'b1;
					cmd.first = at_start_q;
					if (!at_start_q || last_vertex) begin
						state_d = S_SETUP;
					end
				end
			end
			S_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = S_MUL1;
			end
			S_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = S_CMP;
			end
			S_CMP: begin
				cmd.cmp = 1'b1;
				if (close_q) begin
					state_d = S_OUT;
				end else if (last_q) begin
					state_d = S_SETUP;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			at_start_q  <= 1'b1;
			last_q      <= 1'b0;
			close_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				last_q     <= last_vertex;
				at_start_q <= 1'b0;
				// A first vertex that is also last goes straight to the closing edge.
				close_q    <= at_start_q;
			end
			if ((state_q == S_CMP) && !close_q && last_q) begin
				close_q <= 1'b1;
			end
			if (cmd.out_load) begin
				at_start_q  <= 1'b1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== design/point_in_polygon_even_odd_core.sv =====
// Channel | Handshake            | Payload
// --------+----------------------+-------------------------------------------------
// in      | in_valid / in_ready  | vertex_x, vertex_y, query_x, query_y, last_vertex
// out     | out_valid / out_ready| inside_res
//
// A first vertex that is not last is only stored; every other vertex runs the edge
// it closes through setup, two multiplies and the compare, and a last vertex then
// runs the closing edge the same way before the result is loaded. A lone vertex
// that is both first and last runs only the closing edge before the result load.
// One 33 x 33 bit multiplier forms both cross products of an edge in turn before the compare.
// Reset (arst_n low) returns the sequencer to idle, expecting a first vertex.
// A result still waiting holds the sequencer after the next closing edge, and no
// request is taken until that result has left.
module point_in_polygon_even_odd_core
	import pip_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  coord_t vertex_x,
	input  coord_t vertex_y,
	input  coord_t query_x,
	input  coord_t query_y,
	input  logic   last_vertex,
	output logic   out_valid,
	input  logic   out_ready,
	output logic   inside_res
);

	// Command bundle from the sequencer. The datapath holds all coordinates, the
	// parity bit and the shared multiplier; the sequencer walks each edge through
	// setup, two multiplies and the compare, and owns the result valid flag.
	pip_cmd_t cmd;

	pip_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.last_vertex (last_vertex),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.cmd         (cmd)
	);

	// The query point is captured with the first vertex of each polygon. An edge
	// toggles parity when it straddles the query y, has an endpoint at or left of
	// the query x, and its crossing lies strictly left, decided exactly by
	// comparing the full-width cross products with the sign of the y difference.
	pip_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.vertex_x   (vertex_x),
		.vertex_y   (vertex_y),
		.query_x    (query_x),
		.query_y    (query_y),
		.inside_res (inside_res)
	);

endmodule

// ===== tb/sv/pip_inside_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the point-in-polygon core, predicts the inside flag
// of every polygon and compares it with the result the core delivers.
module pip_inside_checker
	import pip_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	input  logic   in_ready,
	input  coord_t vertex_x,
	input  coord_t vertex_y,
	input  coord_t query_x,
	input  coord_t query_y,
	input  logic   last_vertex,
	input  logic   out_valid,
	input  logic   out_ready,
	input  logic   inside_res,
	output int     mismatch_count,
	output int     pending_count,
	output int     result_count,
	output int     inside_count
);

	coord_t first_x, first_y, prev_x, prev_y, ray_x, ray_y;
	logic   parity, at_start;
	logic   inside_q[$];
	int     mismatches, results, insides;

	// True when the edge from a to b flips the parity of a ray cast from p towards -x.
	function automatic logic ray_crossing(input coord_t ax, input coord_t ay,
			input coord_t bx, input coord_t by, input coord_t px, input coord_t py);
		longint ax_l = ax;
		longint ay_l = ay;
		longint bx_l = bx;
		longint by_l = by;
		longint px_l = px;
		longint py_l = py;
		longint dy;
		logic signed [127:0] lhs, rhs;
		logic left_of, straddles;
		left_of   = (ax <= px) || (bx <= px);
		straddles = (ay < py && by >= py) || (by < py && ay >= py);
		if (!(left_of && straddles))
			return 1'b0;
		dy  = by_l - ay_l;
		lhs = (py_l - ay_l) * (bx_l - ax_l);
		rhs = (px_l - ax_l) * dy;
		return (dy > 0) ? (lhs < rhs) : (lhs > rhs);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic expected;
		if (!arst_n) begin
			first_x  = '0;
			first_y  = '0;
			prev_x   = '0;
			prev_y   = '0;
			ray_x    = '0;
			ray_y    = '0;
			parity   = 1'b0;
			at_start = 1'b1;
			inside_q.delete();
			mismatches = 0;
			results    = 0;
			insides    = 0;
		end else begin
			if (out_valid && out_ready) begin
				results++;
				if (inside_res)
					insides++;
				if (inside_q.size() == 0) begin
					$error("inside_res: result with none expected, actual %0b", inside_res);
					mismatches++;
				end else begin
					expected = inside_q.pop_front();
					if (inside_res !== expected) begin
						$error("inside_res mismatch: expected %0b, actual %0b",
							expected, inside_res);
						mismatches++;
					end
				end
			end
			if (in_valid && in_ready) begin
				if (at_start) begin
					ray_x    = query_x;
					ray_y    = query_y;
					first_x  = vertex_x;
					first_y  = vertex_y;
					parity   = 1'b0;
					at_start = 1'b0;
				end else begin
					parity ^= ray_crossing(prev_x, prev_y, vertex_x, vertex_y, ray_x, ray_y);
				end
				prev_x = vertex_x;
				prev_y = vertex_y;
				if (last_vertex) begin
					parity ^= ray_crossing(vertex_x, vertex_y, first_x, first_y,
						ray_x, ray_y);
					inside_q = {inside_q, parity};
					at_start = 1'b1;
				end
			end
		end
		mismatch_count <= mismatches;
		pending_count  <= inside_q.size();
		result_count   <= results;
		inside_count   <= insides;
	end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the even-odd point-in-polygon core. Polygons are
// streamed one vertex per request; a separate checker predicts the inside flag
// of every polygon and counts mismatches, which this module turns into the
// final verdict.
module testbench;
	import pip_pkg::*;

	// Handy Q16.16 values for the directed polygons.
	localparam coord_t ONE  = 32'sh0001_0000;
	localparam coord_t MINC = 32'sh8000_0000;
	localparam coord_t MAXC = 32'sh7fff_ffff;

	logic   clk         = 1'b0;
	logic   arst_n      = 1'b0;
	logic   in_valid    = 1'b0;
	logic   in_ready;
	coord_t vertex_x    = '0;
	coord_t vertex_y    = '0;
	coord_t query_x     = '0;
	coord_t query_y     = '0;
	logic   last_vertex = 1'b0;
	logic   out_valid;
	logic   out_ready   = 1'b0;
	logic   inside_res;

	int mismatch_count, pending_count, result_count, inside_count;

	// Idle percentages of the current phase for the sending and receiving side.
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int vertices_sent  = 0;

	always #5 clk = ~clk;

	point_in_polygon_even_odd_core DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.vertex_x    (vertex_x),
		.vertex_y    (vertex_y),
		.query_x     (query_x),
		.query_y     (query_y),
		.last_vertex (last_vertex),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.inside_res  (inside_res)
	);

	pip_inside_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.vertex_x       (vertex_x),
		.vertex_y       (vertex_y),
		.query_x        (query_x),
		.query_y        (query_y),
		.last_vertex    (last_vertex),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.inside_res     (inside_res),
		.mismatch_count (mismatch_count),
		.pending_count  (pending_count),
		.result_count   (result_count),
		.inside_count   (inside_count)
	);

	// The receiver stalls at random, one fresh decision per clock edge.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Presents one vertex request and returns at the edge where it is taken.
	// The sender may first sit idle for a random number of cycles. Between two
	// back-to-back requests valid simply stays high, so it is never dropped and
	// raised within the same time step.
	task automatic send_vertex(input coord_t vx, input coord_t vy, input coord_t qx,
			input coord_t qy, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		vertex_x    <= vx;
		vertex_y    <= vy;
		query_x     <= qx;
		query_y     <= qy;
		last_vertex <= last;
		do
			@(posedge clk);
		while (!in_ready);
		vertices_sent++;
	endtask

	// Picks a coordinate. Most land close to the query point so that edges
	// straddle the ray and the exact crossing compare is exercised near its
	// ties; the rest are near the previous coordinate, anywhere in range or at the
	// extremes, which stresses the full-width products.
	function automatic coord_t pick_coord(input coord_t center, input coord_t prev);
		case ($urandom_range(11))
			0:       return $urandom();
			1:       return center;
			2:       return $urandom_range(1) ? MAXC : MINC;
			3:       return prev + $urandom_range(16) - 8;
			4, 5, 6: return center + $urandom_range(16) - 8;
			default: return center + ($signed($urandom()) >>> $urandom_range(6, 24));
		endcase
	endfunction

	// One random polygon. Mostly a handful of vertices, now and then a long one
	// or a lone vertex. Some edges are made horizontal or of zero length on
	// purpose. The query fields of later vertices carry junk, which the core must
	// ignore.
	task automatic send_random_polygon();
		int     count;
		coord_t qx, qy, vx, vy, px, py;
		count = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
		case ($urandom_range(4))
			0: begin
				qx = $urandom_range(1) ? MAXC : MINC;
				qy = $urandom_range(1) ? MAXC : MINC;
			end
			1: begin
				qx = $urandom_range(64) - 32;
				qy = $urandom_range(64) - 32;
			end
			default: begin
				qx = $urandom();
				qy = $urandom();
			end
		endcase
		px = qx;
		py = qy;
		for (int i = 0; i < count; i++) begin
			vx = pick_coord(qx, px);
			vy = pick_coord(qy, py);
			if (i > 0) begin
				case ($urandom_range(19))
					0:    begin vx = px; vy = py; end
					1, 2: vy = py;
					default: ;
				endcase
			end
			if (i == 0)
				send_vertex(vx, vy, qx, qy, count == 1);
			else
				send_vertex(vx, vy, $urandom(), $urandom(), i == count - 1);
			px = vx;
			py = vy;
		end
	endtask

	// Drops valid and holds the sender back until every expected inside flag
	// has come out. The first edge is always waited for, so the checker has
	// seen the request taken at this very edge before its count is trusted.
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_count != 0);
	endtask

	// A stretch of random polygons under one idle pattern.
	task automatic run_phase(input int send_idle, input int recv_stall, input int vertices);
		int stop_at;
		stop_at        = vertices_sent + vertices;
		send_idle_pct  = send_idle;
		recv_stall_pct = recv_stall;
		while (vertices_sent < stop_at)
			send_random_polygon();
		drain();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed polygons, sent without any idling.
		// A lone vertex is a polygon whose only edge closes on itself: outside.
		send_vertex(0, 0, 0, 0, 1'b1);
		// A square around the origin with the query at its center: inside. The
		// query fields of later vertices point elsewhere and must be ignored.
		send_vertex(-ONE, -ONE, 0, 0, 1'b0);
		send_vertex(ONE, -ONE, MAXC, MAXC, 1'b0);
		send_vertex(ONE, ONE, MINC, MINC, 1'b0);
		send_vertex(-ONE, ONE, 3 * ONE, 0, 1'b1);
		// The same square with the query to its right: outside.
		send_vertex(-ONE, -ONE, 3 * ONE, 0, 1'b0);
		send_vertex(ONE, -ONE, 0, 0, 1'b0);
		send_vertex(ONE, ONE, 0, 0, 1'b0);
		send_vertex(-ONE, ONE, 0, 0, 1'b1);
		// Triangles spanning the whole coordinate range, the widest differences
		// and products there are.
		send_vertex(MINC, MINC, 0, 0, 1'b0);
		send_vertex(MAXC, MINC, 0, 0, 1'b0);
		send_vertex(MAXC, MAXC, 0, 0, 1'b1);
		send_vertex(MAXC, MAXC, MINC, MAXC, 1'b0);
		send_vertex(MINC, MINC, 0, 0, 1'b0);
		send_vertex(MAXC, MINC, 0, 0, 1'b1);
		// Horizontal and zero-length edges, which never count as crossings.
		send_vertex(-ONE, 0, 0, 0, 1'b0);
		send_vertex(ONE, 0, 0, 0, 1'b0);
		send_vertex(ONE, 0, 0, 0, 1'b0);
		send_vertex(0, 0, 0, 0, 1'b1);
		// A triangle with the query sitting on one of its corners.
		send_vertex(0, 0, 0, 0, 1'b0);
		send_vertex(2 * ONE, -ONE, 0, 0, 1'b0);
		send_vertex(2 * ONE, ONE, 0, 0, 1'b1);
		// The sender waits here until every directed result has come out.
		drain();

		// Random polygons under each idle pattern, ending with a quiet stretch.
		run_phase(0, 0, 265);
		run_phase(74, 0, 265);
		run_phase(0, 74, 265);
		run_phase(36, 36, 265);
		run_phase(0, 0, 265);

		// The bench keeps clocking before the report to catch any result the core
		// might still push out.
		repeat (20) @(posedge clk);

		$display("Sent %0d vertices; %0d polygon results checked, %0d of them inside.",
			vertices_sent, result_count, inside_count);
		$display("Idle patterns: none, sender 74%%, receiver 74%%, both 36%%, none.");
		if (mismatch_count == 0 && pending_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// The timeout allows far more time than a correct run needs.
	initial begin
		#5_000_000;
		$display("Timeout: %0d vertices sent, %0d results still expected.",
			vertices_sent, pending_count);
		$display("Some tests failed");
		$finish;
	end

endmodule
